[hw/rtl/sdtq_pkg.sv]
// Shared types, constants and helpers of the sorted deadline timer queue.
package sdtq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 8;

    localparam int SEC_W  = 33;
    localparam int USEC_W = 20;
    localparam int DLY_W  = 31;
    localparam int QUO_W  = 22;
    localparam int REM_W  = 10;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [REM_W-1:0]  MS_PER_SEC   = 10'd1000;
    localparam logic [31:0]       DIV_MUL      = 32'd2199023256;
    localparam int                DIV_SHIFT    = 41;
    localparam int                PROD_W       = DLY_W + 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_NONE   = 2'd3
    } op_e;

    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_EXPIRED = 2'd2,
        KIND_WAIT    = 2'd3
    } kind_e;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_SCAN,
        CMD_PACK,
        CMD_SHIFT
    } cmd_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_DIV,
        ST_ADD_REM,
        ST_ADD_NORM,
        ST_ADD_INS,
        ST_REM_SCAN,
        ST_REM_PACK,
        ST_EXP_POP,
        ST_REPORT
    } state_e;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
    } tim_t;

    typedef struct packed {
        cmd_e op;
        tim_t tim;
    } ctl_t;

    function automatic logic not_after(tim_t a, tim_t b);
        return (a.sec < b.sec) || ((a.sec == b.sec) && (a.usec <= b.usec));
    endfunction

endpackage

[hw/rtl/sorted_deadline_timer_queue.sv]
// Top level of the sorted deadline timer queue: sequencer, cell chain, result register.
//
// Input channel (in_valid/in_stall) takes one command: add, remove or expire,
// with the current time. Output channel (out_valid/out_stall) returns results.
// The queue is a chain of DEPTH cells kept in deadline order; cell 0 is the head.
// One command is worked at a time; in_stall is high while a command is busy,
// and the next command is taken in the idle cycle after the last result loads.
// Add: divide by 1000 through a reciprocal multiply, remainder, normalize,
//   insert into the chain (skipped when the chain is full), then report.
// Remove: a token walks the chain and drops matching cells, compaction then
//   closes the gaps, then the result is reported.
// Expire: due entries are popped from the head, one per cycle while the output
//   register is free; once the head is not due, a report gives the wait result.
// Results sit in one output register; a new result loads in the cycle the
// previous one transfers, so a stall on the output holds the expire and report states.
// Reset clears all cell valid bits, the sequencer and the output valid bit:
// the queue starts empty and needs no clearing pass.
module sorted_deadline_timer_queue #(
    parameter int DEPTH       = sdtq_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = sdtq_pkg::HANDLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  owner_handle,
    input  logic [30:0] delay_ms,
    input  logic [31:0] now_sec,
    input  logic [19:0] now_usec,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  expired_handle,
    output logic        became_head,
    output logic        queue_full,
    output logic [4:0]  removed_count,
    output logic        has_head,
    output logic [32:0] wait_sec,
    output logic [19:0] wait_usec,
    output logic        last
);
    import sdtq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_e                 state_reg, state_next;
    op_e                    op_reg;
    logic [HANDLE_BITS-1:0] key_reg;
    logic [DLY_W-1:0]       delay_reg;
    tim_t                   now_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [QUO_W-1:0]       quo_reg;
    logic [REM_W-1:0]       rem_reg;
    tim_t                   dl_reg;
    logic                   head_reg;
    logic                   full_reg;
    logic [CNT_W-1:0]       removed_reg;

    ctl_t                   ctl;
    logic                   tok_in;
    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic                   out_last;
    kind_e                  out_kind;

    logic                   out_valid_reg;
    kind_e                  kind_reg;
    logic [7:0]             exp_handle_reg;
    logic                   head_out_reg;
    logic                   full_out_reg;
    logic [4:0]             removed_out_reg;
    logic                   has_head_reg;
    logic [SEC_W-1:0]       wait_sec_reg;
    logic [USEC_W-1:0]      wait_usec_reg;
    logic                   last_reg;

    tim_t                   cell_tim   [DEPTH];
    logic [HANDLE_BITS-1:0] cell_owner [DEPTH];
    logic [DEPTH-1:0]       cell_valid;
    logic [DEPTH-1:0]       cell_le;
    logic [DEPTH-1:0]       cell_tok;
    logic [DEPTH-1:0]       cell_hit;
    logic [DEPTH-2:0]       gap;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            tim_t                   l_tim, r_tim;
            logic [HANDLE_BITS-1:0] l_owner, r_owner;
            logic                   l_valid, l_le, l_tok, r_valid;
            if (g == 0)
            begin : g_first
                assign l_tim   = ctl.tim;
                assign l_owner = key_reg;
                assign l_valid = 1'b1;
                assign l_le    = 1'b1;
                assign l_tok   = tok_in;
            end
            else
            begin : g_mid
                assign l_tim   = cell_tim[g-1];
                assign l_owner = cell_owner[g-1];
                assign l_valid = cell_valid[g-1];
                assign l_le    = cell_le[g-1];
                assign l_tok   = cell_tok[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_end
                assign r_tim   = cell_tim[g];
                assign r_owner = cell_owner[g];
                assign r_valid = 1'b0;
            end
            else
            begin : g_inner
                assign r_tim   = cell_tim[g+1];
                assign r_owner = cell_owner[g+1];
                assign r_valid = cell_valid[g+1];
                assign gap[g]  = !cell_valid[g] && cell_valid[g+1];
            end
            sdtq_cell #(
                .HANDLE_BITS(HANDLE_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .key        (key_reg),
                .left_tim   (l_tim),
                .left_owner (l_owner),
                .left_valid (l_valid),
                .left_le    (l_le),
                .left_tok   (l_tok),
                .right_tim  (r_tim),
                .right_owner(r_owner),
                .right_valid(r_valid),
                .tim        (cell_tim[g]),
                .owner      (cell_owner[g]),
                .valid      (cell_valid[g]),
                .le         (cell_le[g]),
                .tok        (cell_tok[g]),
                .hit        (cell_hit[g])
            );
        end
    endgenerate

    logic                    now_carry;
    logic [USEC_W-1:0]       now_usec_n;
    logic [QUO_W+REM_W-1:0]  quo_x;
    logic [USEC_W:0]         du_raw;
    logic [SEC_W-1:0]        ds_raw;
    logic                    head_due;
    logic [SEC_W-1:0]        ws;
    logic [USEC_W-1:0]       wu;
    logic [USEC_W:0]         wu_wide;

    assign now_carry  = (now_usec >= USEC_PER_SEC);
    assign now_usec_n = now_carry ? (now_usec - USEC_PER_SEC) : now_usec;
    assign quo_x      = {{REM_W{1'b0}}, prod_reg[PROD_W-1:DIV_SHIFT]}
                        * {{QUO_W{1'b0}}, MS_PER_SEC};
    assign du_raw     = {1'b0, now_reg.usec}
                        + ({11'b0, rem_reg} * {11'b0, MS_PER_SEC});
    assign ds_raw     = now_reg.sec + SEC_W'(quo_reg);
    assign head_due   = cell_valid[0] && not_after(cell_tim[0], now_reg);
    assign wu_wide    = {1'b0, cell_tim[0].usec} + {1'b0, USEC_PER_SEC}
                        - {1'b0, now_reg.usec};

    always_comb
    begin
        ws = '0;
        wu = '0;
        if (cell_valid[0] && !head_due)
        begin
            if (cell_tim[0].usec >= now_reg.usec)
            begin
                ws = cell_tim[0].sec - now_reg.sec;
                wu = cell_tim[0].usec - now_reg.usec;
            end
            else
            begin
                ws = cell_tim[0].sec - now_reg.sec - SEC_W'(1);
                wu = wu_wide[USEC_W-1:0];
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = CMD_HOLD;
        ctl.tim    = dl_reg;
        tok_in     = 1'b0;
        accept     = 1'b0;
        out_load   = 1'b0;
        out_last   = 1'b1;
        out_kind   = KIND_WAIT;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    accept = 1'b1;
                    case (operation)
                        OP_ADD:    state_next = ST_ADD_DIV;
                        OP_REMOVE:
                        begin
                            state_next = ST_REM_SCAN;
                            tok_in     = 1'b1;
                        end
                        OP_EXPIRE: state_next = ST_EXP_POP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_DIV:  state_next = ST_ADD_REM;
            ST_ADD_REM:  state_next = ST_ADD_NORM;
            ST_ADD_NORM: state_next = ST_ADD_INS;
            ST_ADD_INS:
            begin
                if (!cell_valid[DEPTH-1])
                    ctl.op = CMD_INSERT;
                state_next = ST_REPORT;
            end
            ST_REM_SCAN:
            begin
                ctl.op = CMD_SCAN;
                if (cell_tok[DEPTH-1])
                    state_next = ST_REM_PACK;
            end
            ST_REM_PACK:
            begin
                if (|gap)
                    ctl.op = CMD_PACK;
                else
                    state_next = ST_REPORT;
            end
            ST_EXP_POP:
            begin
                if (head_due)
                begin
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        out_last = 1'b0;
                        out_kind = KIND_EXPIRED;
                        ctl.op   = CMD_SHIFT;
                    end
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                case (op_reg)
                    OP_ADD:    out_kind = KIND_ADD;
                    OP_REMOVE: out_kind = KIND_REMOVE;
                    default:   out_kind = KIND_WAIT;
                endcase
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op_e'(operation);
            key_reg      <= HANDLE_BITS'(owner_handle);
            delay_reg    <= delay_ms;
            now_reg.sec  <= {1'b0, now_sec} + SEC_W'(now_carry);
            now_reg.usec <= now_usec_n;
            removed_reg  <= '0;
            head_reg     <= 1'b0;
            full_reg     <= 1'b0;
        end
        prod_reg <= {32'b0, delay_reg} * {{DLY_W{1'b0}}, DIV_MUL};
        if (state_reg == ST_ADD_REM)
        begin
            quo_reg <= prod_reg[PROD_W-1:DIV_SHIFT];
            rem_reg <= REM_W'(delay_reg - quo_x[DLY_W-1:0]);
        end
        if (state_reg == ST_ADD_NORM)
        begin
            if (du_raw >= {1'b0, USEC_PER_SEC})
            begin
                dl_reg.sec  <= ds_raw + SEC_W'(1);
                dl_reg.usec <= USEC_W'(du_raw - {1'b0, USEC_PER_SEC});
            end
            else
            begin
                dl_reg.sec  <= ds_raw;
                dl_reg.usec <= du_raw[USEC_W-1:0];
            end
        end
        if (state_reg == ST_ADD_INS)
        begin
            full_reg <= cell_valid[DEPTH-1];
            head_reg <= !cell_valid[DEPTH-1] && !cell_le[0];
        end
        if ((state_reg == ST_REM_SCAN) && (|cell_hit))
            removed_reg <= removed_reg + CNT_W'(1);
        if (out_load)
        begin
            kind_reg <= out_kind;
            last_reg <= out_last;
            if (out_kind == KIND_EXPIRED)
            begin
                exp_handle_reg  <= 8'(cell_owner[0]);
                head_out_reg    <= 1'b0;
                full_out_reg    <= 1'b0;
                removed_out_reg <= '0;
                has_head_reg    <= 1'b0;
                wait_sec_reg    <= '0;
                wait_usec_reg   <= '0;
            end
            else
            begin
                exp_handle_reg  <= '0;
                head_out_reg    <= head_reg;
                full_out_reg    <= full_reg;
                removed_out_reg <= 5'(removed_reg);
                has_head_reg    <= cell_valid[0];
                wait_sec_reg    <= ws;
                wait_usec_reg   <= wu;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign expired_handle = exp_handle_reg;
    assign became_head    = head_out_reg;
    assign queue_full     = full_out_reg;
    assign removed_count  = removed_out_reg;
    assign has_head       = has_head_reg;
    assign wait_sec       = wait_sec_reg;
    assign wait_usec      = wait_usec_reg;
    assign last           = last_reg;

endmodule

[hw/rtl/sdtq_cell.sv]
// One slot of the sorted timer chain: deadline, owner, valid and scan token.
module sdtq_cell #(
    parameter int HANDLE_BITS = sdtq_pkg::HANDLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdtq_pkg::ctl_t         ctl,
    input  logic [HANDLE_BITS-1:0] key,
    input  sdtq_pkg::tim_t         left_tim,
    input  logic [HANDLE_BITS-1:0] left_owner,
    input  logic                   left_valid,
    input  logic                   left_le,
    input  logic                   left_tok,
    input  sdtq_pkg::tim_t         right_tim,
    input  logic [HANDLE_BITS-1:0] right_owner,
    input  logic                   right_valid,
    output sdtq_pkg::tim_t         tim,
    output logic [HANDLE_BITS-1:0] owner,
    output logic                   valid,
    output logic                   le,
    output logic                   tok,
    output logic                   hit
);
    import sdtq_pkg::*;

    tim_t                   tim_reg, tim_next;
    logic [HANDLE_BITS-1:0] owner_reg, owner_next;
    logic                   valid_reg, valid_next;
    logic                   tok_reg;

    assign tim   = tim_reg;
    assign owner = owner_reg;
    assign valid = valid_reg;
    assign tok   = tok_reg;
    assign le    = valid_reg && not_after(tim_reg, ctl.tim);
    assign hit   = tok_reg && valid_reg && (owner_reg == key);

    always_comb
    begin
        tim_next   = tim_reg;
        owner_next = owner_reg;
        valid_next = valid_reg;
        case (ctl.op)
            CMD_INSERT:
            begin
                if (!le)
                begin
                    if (left_le)
                    begin
                        tim_next   = ctl.tim;
                        owner_next = key;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        tim_next   = left_tim;
                        owner_next = left_owner;
                        valid_next = left_valid;
                    end
                end
            end
            CMD_SCAN:
            begin
                if (hit)
                    valid_next = 1'b0;
            end
            CMD_PACK:
            begin
                if (!valid_reg)
                begin
                    tim_next   = right_tim;
                    owner_next = right_owner;
                    valid_next = right_valid;
                end
                else if (!left_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            CMD_SHIFT:
            begin
                tim_next   = right_tim;
                owner_next = right_owner;
                valid_next = right_valid;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= left_tok;
        end
    end

    always_ff @(posedge clk)
    begin
        tim_reg   <= tim_next;
        owner_reg <= owner_next;
    end

endmodule
